>>> design/arcade_io_latch_and_pixel_gen_top_defines.svh
// assertion helpers used by the top-level design file
// clocked on clk and held off while arst_n is low
`ifndef ARCADE_IO_LATCH_AND_PIXEL_GEN_TOP_DEFINES_SVH
`define ARCADE_IO_LATCH_AND_PIXEL_GEN_TOP_DEFINES_SVH

// same-cycle implication
`define AIO_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("aio assertion failed");

// next-cycle implication
`define AIO_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("aio assertion failed");

`endif

>>> design/aio_pkg.sv
package aio_pkg;

	localparam int unsigned VideoBytesDefault = 16384;
	localparam int unsigned OffsetW = 14;
	localparam int unsigned ApbAddrW = 3;
	localparam int unsigned ApbDataW = 32;

	typedef enum logic [1:0] {
		OP_PORT1 = 2'd0,
		OP_PORT2 = 2'd1,
		OP_PORT3 = 2'd2,
		OP_VIDEO = 2'd3
	} aio_op_t;

	// register index decoded from paddr[2]
	localparam logic REG_PALETTE = 1'b0;

	localparam logic [2:0] CLR_RED = 3'd2;

	typedef struct packed {
		logic flip;
		logic red;
		logic bank;
	} aio_latch_t;

	typedef struct packed {
		logic [5:0] start_mask;
		logic       stop_ch5;
		logic       loop_ch5;
		logic       alt_ch3;
		logic       alt_ch6;
	} aio_snd_t;

	typedef struct packed {
		logic [7:0]      row;
		logic [7:0]      col;
		logic            leftward;
		logic [3:0][2:0] pix;
	} aio_vid_t;

	// colour prom, both tables, by byte column, 32-row band and bank
	function automatic logic [2:0] aio_prom_colour(input logic tbl, input logic [5:0] c,
			input logic [2:0] band, input logic bank);
		logic       narrow;
		logic [2:0] res;
		narrow = (band == 3'd3) || (band == 3'd4);
		if (c <= 6'd16) begin
			if (c <= 6'd2 && band >= 3'd5) begin
				res = 3'd3;
			end else if (bank && (c == 6'd3 || c == 6'd4)) begin
				res = 3'd2;
			end else begin
				res = 3'd6;
			end
		end else if (c <= 6'd24) begin
			res = 3'd3;
		end else if (c <= 6'd32) begin
			// middle strip is the only part that differs between tables
			if (tbl) begin
				res = narrow ? 3'd6 : 3'd7;
			end else begin
				res = narrow ? 3'd4 : 3'd5;
			end
		end else if (c <= 6'd40) begin
			res = 3'd3;
		end else if (c <= 6'd48) begin
			res = 3'd2;
		end else if (c <= 6'd56) begin
			res = 3'd6;
		end else begin
			res = 3'd4;
		end
		return res;
	endfunction

endpackage

>>> design/arcade_io_latch_and_pixel_gen_top.sv
// latency: a result is valid the cycle after its item is accepted
// throughput: one item per cycle while the result register is empty or being drained, set by the single result register
// item_ready stays high while the result register is empty or being drained
// reset clears the port latches, previous port bytes, palette switch and result valid
`include "arcade_io_latch_and_pixel_gen_top_defines.svh"
module arcade_io_latch_and_pixel_gen_top #(
	parameter int unsigned VIDEO_BYTES = aio_pkg::VideoBytesDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [aio_pkg::ApbAddrW-1:0]  paddr,
	input  logic [aio_pkg::ApbDataW-1:0]  pwdata,
	output logic [aio_pkg::ApbDataW-1:0]  prdata,
	output logic                          pready,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic [1:0]                    op,
	input  logic [7:0]                    data,
	input  logic [aio_pkg::OffsetW-1:0]   video_offset,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic [5:0]                    start_mask,
	output logic                          stop_ch5,
	output logic                          loop_ch5,
	output logic                          alt_ch3,
	output logic                          alt_ch6,
	output logic [7:0]                    row,
	output logic [7:0]                    col,
	output logic                          leftward,
	output logic [2:0]                    pix0,
	output logic [2:0]                    pix1,
	output logic [2:0]                    pix2,
	output logic [2:0]                    pix3
);
	import aio_pkg::*;

	logic       palette_q;
	logic [1:0] palette_sw_q;
	logic       fire;
	logic       valid_q;
	aio_snd_t   snd;
	aio_vid_t   vid;
	aio_latch_t latch;
	aio_snd_t   snd_q;
	aio_vid_t   vid_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_sw_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == REG_PALETTE) begin
			palette_sw_q <= pwdata[1:0];
		end
	end

	assign palette_q = |palette_sw_q;
	assign prdata = (paddr[2] == REG_PALETTE) ? {{(ApbDataW-2){1'b0}}, palette_sw_q} : '0;

	assign item_ready = ~valid_q | result_ready;
	assign fire = item_valid & item_ready;

	aio_ports u_ports (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.op     (op),
		.data   (data),
		.snd    (snd),
		.latch  (latch)
	);

	aio_video #(
		.VIDEO_BYTES (VIDEO_BYTES)
	) u_video (
		.is_video     (aio_op_t'(op) == OP_VIDEO),
		.data         (data),
		.video_offset (video_offset),
		.palette_alt  (palette_q),
		.latch        (latch),
		.vid          (vid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (item_ready) begin
			valid_q <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			snd_q <= snd;
			vid_q <= vid;
		end
	end

	assign result_valid = valid_q;
	assign start_mask   = snd_q.start_mask;
	assign stop_ch5     = snd_q.stop_ch5;
	assign loop_ch5     = snd_q.loop_ch5;
	assign alt_ch3      = snd_q.alt_ch3;
	assign alt_ch6      = snd_q.alt_ch6;
	assign row          = vid_q.row;
	assign col          = vid_q.col;
	assign leftward     = vid_q.leftward;
	assign pix0         = vid_q.pix[0];
	assign pix1         = vid_q.pix[1];
	assign pix2         = vid_q.pix[2];
	assign pix3         = vid_q.pix[3];

	`AIO_ASSERT_NEXT(a_accept_gives_result, item_valid && item_ready, result_valid)
	`AIO_ASSERT_IMPL(a_empty_takes_item, !result_valid, item_ready)
	`AIO_ASSERT_IMPL(a_loop_needs_start, result_valid && loop_ch5, start_mask[4])
	`AIO_ASSERT_IMPL(a_alt3_needs_start, result_valid && alt_ch3, start_mask[2])
	`AIO_ASSERT_IMPL(a_sound_no_video, result_valid && start_mask != 6'd0, {row, col, leftward} == '0)

endmodule

>>> design/aio_ports.sv
module aio_ports (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [1:0]        op,
	input  logic [7:0]        data,
	output aio_pkg::aio_snd_t snd,
	output aio_pkg::aio_latch_t latch
);
	import aio_pkg::*;

	logic [7:0] prev_one_q;
	logic [7:0] prev_two_q;
	logic       sound_on_q;
	logic       ch3_alt_q;
	logic       flip_q;
	logic       red_q;
	logic       bank_q;
	logic [7:0] rise_one;
	logic [7:0] rise_two;
	aio_op_t    op_t;

	assign op_t = aio_op_t'(op);
	assign rise_one = data & ~prev_one_q;
	assign rise_two = data & ~prev_two_q;

	always_comb begin
		snd = '0;
		case (op_t)
			OP_PORT1: begin
				// enable comes from the same byte
				if (rise_one[5] && data[7]) begin
					snd.start_mask[4] = 1'b1;
					snd.loop_ch5 = ~data[2];
				end
				snd.stop_ch5 = ~data[5] & prev_one_q[5];
			end
			OP_PORT2: begin
				if (sound_on_q) begin
					snd.start_mask[3:0] = rise_two[3:0];
					snd.alt_ch3 = rise_two[2] & ch3_alt_q;
				end
			end
			OP_PORT3: begin
				if (sound_on_q && (data[6] || data[7])) begin
					snd.start_mask[5] = 1'b1;
					snd.alt_ch6 = ~data[6];
				end
			end
			default: begin
				snd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_one_q <= '0;
			prev_two_q <= '0;
			sound_on_q <= 1'b0;
			ch3_alt_q  <= 1'b0;
			flip_q     <= 1'b0;
			red_q      <= 1'b0;
			bank_q     <= 1'b0;
		end else if (fire) begin
			case (op_t)
				OP_PORT1: begin
					prev_one_q <= data;
					sound_on_q <= data[7];
				end
				OP_PORT2: begin
					prev_two_q <= data;
					flip_q     <= data[4];
					red_q      <= ~data[5];
					bank_q     <= data[6];
					if (sound_on_q && rise_two[2]) begin
						ch3_alt_q <= ~ch3_alt_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign latch.flip = flip_q;
	assign latch.red  = red_q;
	assign latch.bank = bank_q;

endmodule

>>> design/aio_video.sv
module aio_video #(
	parameter int unsigned VIDEO_BYTES = aio_pkg::VideoBytesDefault
) (
	input  logic                  is_video,
	input  logic [7:0]            data,
	input  logic [aio_pkg::OffsetW-1:0] video_offset,
	input  logic                  palette_alt,
	input  aio_pkg::aio_latch_t   latch,
	output aio_pkg::aio_vid_t     vid
);
	import aio_pkg::*;

	localparam logic [OffsetW:0] VidLimit = (OffsetW+1)'(VIDEO_BYTES);

	logic       in_range;
	logic [7:0] x;
	logic [7:0] y;
	logic [2:0] colour;

	assign in_range = {1'b0, video_offset} < VidLimit;
	assign y = video_offset[13:6];
	assign x = {video_offset[5:0], 2'b00};

	always_comb begin
		if (latch.red) begin
			colour = CLR_RED;
		end else begin
			colour = aio_prom_colour(palette_alt, video_offset[5:0], y[7:5], latch.bank);
		end
	end

	always_comb begin
		vid = '0;
		if (is_video && in_range) begin
			// 255 - v is the bitwise inverse
			vid.row      = latch.flip ? ~y : y;
			vid.col      = latch.flip ? ~x : x;
			vid.leftward = latch.flip;
			for (int i = 0; i < 4; i++) begin
				vid.pix[i] = data[i] ? colour : 3'd0;
			end
		end
	end

endmodule
